### design/multi_slot_timeout_timer_top_assert.svh
// Assertion macros used by the timeout timer checker.
`ifndef MULTI_SLOT_TIMEOUT_TIMER_TOP_ASSERT_SVH
`define MULTI_SLOT_TIMEOUT_TIMER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define MSTO_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define MSTO_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/msto_pkg.sv
// Shared types and constants of the multi-slot timeout timer.
`timescale 1ns / 1ps
package msto_pkg;

  // Field widths of the command and result words.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned MS_W    = 32;
  localparam int unsigned TICKS_W = 29;

  // Largest tick count that a slot can hold.
  localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

  // Command codes.
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_START  = 2'd1;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

endpackage

### design/msto_ram.sv
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
module msto_ram #(
  parameter int unsigned WIDTH = 29,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/msto_tick_div.sv
// Converts a millisecond timeout into whole ticks, rounding up, by reciprocal multiplication.
`timescale 1ns / 1ps
module msto_tick_div import msto_pkg::*; #(
  parameter int unsigned TICK_MS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MS_W-1:0]    dividend_i,
  output logic               done_o,
  output logic [TICKS_W-1:0] ticks_o
);

  localparam int unsigned HalfW  = MS_W / 2;
  localparam int unsigned RecW   = MS_W + 1;
  localparam int unsigned PartW  = HalfW + RecW;
  localparam int unsigned AccW   = MS_W + RecW;
  localparam int unsigned ShiftL = $clog2(TICK_MS);
  // Rounded-up reciprocal; with this shift the product gives the exact quotient.
  localparam longint unsigned RecipFull =
    ((64'd1 << (MS_W + ShiftL)) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
  localparam logic [RecW-1:0] Recip   = RecW'(RecipFull);
  localparam logic [MS_W-1:0] Divisor = MS_W'(TICK_MS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_QUOT,
    ST_ROUND
  } state_e;

  state_e             state_q;
  logic [MS_W-1:0]    ms_q;
  logic [AccW-1:0]    acc_q;
  logic [MS_W-1:0]    quot_q;
  logic [TICKS_W-1:0] ticks_q;
  logic               done_q;
  logic [HalfW-1:0]   ms_half;
  logic [PartW-1:0]   part;
  logic [MS_W-1:0]    back;
  logic [MS_W:0]      rounded;
  logic [TICKS_W-1:0] ticks_d;

  // One narrow multiplier serves the low and then the high half of the timeout.
  assign ms_half = (state_q == ST_MUL_LO) ? ms_q[HalfW-1:0] : ms_q[MS_W-1:HalfW];
  assign part    = PartW'(ms_half) * PartW'(Recip);

  // Round up when the quotient leaves a remainder, then saturate to the counter width.
  assign back    = quot_q * Divisor;
  assign rounded = {1'b0, quot_q} + (MS_W + 1)'(back != ms_q);
  assign ticks_d = (rounded > (MS_W + 1)'(TICKS_MAX)) ? TICKS_MAX : rounded[TICKS_W-1:0];

  // Four steps: low partial product, high partial product, quotient, rounding.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ms_q    <= '0;
      acc_q   <= '0;
      quot_q  <= '0;
      ticks_q <= '0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            ms_q    <= dividend_i;
            state_q <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: begin
          done_q  <= 1'b0;
          acc_q   <= AccW'(part);
          state_q <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          done_q  <= 1'b0;
          acc_q   <= acc_q + (AccW'(part) << HalfW);
          state_q <= ST_QUOT;
        end
        ST_QUOT: begin
          done_q  <= 1'b0;
          quot_q  <= MS_W'(acc_q >> (MS_W + ShiftL));
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          ticks_q <= ticks_d;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign ticks_o = ticks_q;
  assign done_o  = done_q;

endmodule

### design/multi_slot_timeout_timer_top.sv
// Top level of the multi-slot one-shot timeout timer.
// Cancel and unused commands finish in the cycle they are taken; a start holds the
// command channel through the four-step reciprocal tick divider and the slot's count write.
// A tick sweeps the count memory one slot a cycle, pausing while a stalled result word
// blocks a new expiry, and then flushes the last expiry when something expired.
// Reset clears all armed flags and the output; the count memory is not cleared.
`timescale 1ns / 1ps
module multi_slot_timeout_timer_top import msto_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16,
  parameter int unsigned TICK_MS   = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [SLOT_W-1:0] slot_id_i,
  input  logic [MS_W-1:0]   timeout_ms_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SLOT_W-1:0] expired_slot_o,
  output logic              last_expiry_o
);

  localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CmpW = 8;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SWEEP,
    ST_FLUSH
  } state_e;

  state_e              state_q;
  logic [NUM_SLOTS-1:0] armed_q;
  logic [IdxW-1:0]     cur_q;
  logic [IdxW-1:0]     slot_q;
  logic                pend_v_q;
  logic [SLOT_W-1:0]   pend_slot_q;
  logic                out_valid_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic                out_last_q;

  logic                in_accept;
  logic                slot_ok;
  logic [IdxW-1:0]     slot_idx;
  logic                div_start;
  logic                div_done;
  logic [TICKS_W-1:0]  div_ticks;
  logic                out_free;
  logic                expire;
  logic                sweep_hold;
  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  logic [TICKS_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [IdxW-1:0]     ram_raddr;
  logic [TICKS_W-1:0]  ram_rdata;

  // Command decode.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign slot_ok    = (CmpW'(slot_id_i) < CmpW'(NUM_SLOTS));
  assign slot_idx   = IdxW'(slot_id_i);
  assign div_start  = in_accept && (opcode_i == OP_START) && slot_ok;

  // Sweep decisions on the current slot, whose count the RAM read port holds.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign expire     = armed_q[cur_q] && (ram_rdata <= TICKS_W'(1));
  assign sweep_hold = expire && pend_v_q && !out_free;

  msto_tick_div #(
    .TICK_MS (TICK_MS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (timeout_ms_i),
    .done_o     (div_done),
    .ticks_o    (div_ticks)
  );

  // Count memory control: write the slot's count on divider completion, decrement during the sweep.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = ram_rdata - TICKS_W'(1);
    ram_re    = 1'b0;
    ram_raddr = cur_q + IdxW'(1);
    unique case (state_q)
      ST_IDLE: begin
        ram_re    = in_accept && (opcode_i == OP_TICK);
        ram_raddr = '0;
      end
      ST_DIV: begin
        ram_we    = div_done;
        ram_waddr = slot_q;
        ram_wdata = div_ticks;
      end
      ST_SWEEP: begin
        ram_we = !sweep_hold && armed_q[cur_q] && !expire;
        ram_re = !sweep_hold && (cur_q != LastIdx);
      end
      ST_FLUSH: begin
      end
      default: begin
      end
    endcase
  end

  msto_ram #(
    .WIDTH (TICKS_W),
    .DEPTH (NUM_SLOTS)
  ) u_ticks_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer, armed flags and the result word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      armed_q     <= '0;
      cur_q       <= '0;
      slot_q      <= '0;
      pend_v_q    <= 1'b0;
      pend_slot_q <= '0;
      out_valid_q <= 1'b0;
      out_slot_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            unique case (opcode_i)
              OP_TICK: begin
                cur_q   <= '0;
                state_q <= ST_SWEEP;
              end
              OP_START: begin
                if (slot_ok) begin
                  slot_q  <= slot_idx;
                  state_q <= ST_DIV;
                end
              end
              OP_CANCEL: begin
                if (slot_ok) begin
                  armed_q[slot_idx] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            armed_q[slot_q] <= 1'b1;
            state_q         <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          if (!sweep_hold) begin
            // An expiry is held back one step so the last one of a tick can be marked.
            if (expire) begin
              armed_q[cur_q] <= 1'b0;
              pend_slot_q    <= SLOT_W'(cur_q);
              pend_v_q       <= 1'b1;
              if (pend_v_q) begin
                out_valid_q <= 1'b1;
                out_slot_q  <= pend_slot_q;
                out_last_q  <= 1'b0;
              end
            end
            if (cur_q == LastIdx) begin
              state_q <= (pend_v_q || expire) ? ST_FLUSH : ST_IDLE;
            end else begin
              cur_q <= cur_q + IdxW'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_slot_q  <= pend_slot_q;
            out_last_q  <= 1'b1;
            pend_v_q    <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign expired_slot_o = out_slot_q;
  assign last_expiry_o  = out_last_q;

endmodule

### design/msto_checker.sv
// Port-level checker for the timeout timer, bound to the top level.
`timescale 1ns / 1ps
`include "multi_slot_timeout_timer_top_assert.svh"
module msto_checker import msto_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [OP_W-1:0]   opcode_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [SLOT_W-1:0] expired_slot_o,
  input logic              last_expiry_o
);

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled result word keeps its contents.
  `MSTO_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(expired_slot_o) && $stable(last_expiry_o), "stalled result word changed")

  // A tick always starts a sweep, which holds off the next command.
  `MSTO_ASSERT_NXT(a_tick_busy, in_acc && (opcode_i == OP_TICK), in_stall_o, "tick did not start a sweep")

  // A cancel finishes in the cycle it is taken.
  `MSTO_ASSERT_NXT(a_cancel_fast, in_acc && (opcode_i == OP_CANCEL), !in_stall_o, "cancel held the command channel")

  // New result words only come out of a running sweep or its flush step.
  `MSTO_ASSERT_IMP(a_out_from_sweep, $rose(out_valid_o), $past(in_stall_o), "result word appeared outside a sweep")

endmodule

bind multi_slot_timeout_timer_top msto_checker u_msto_checker (.*);
